/* rtl/svam_pkg.sv */
// ----------------------------------------------------------------------------
// svam_pkg: shared types and constants of the striped volume address mapper
// Field widths, register codes, status codes and the words that travel
// alongside the divider chains.
// ----------------------------------------------------------------------------
package svam_pkg;

   // default parameter values
   localparam int MAX_STRIPES_DEF = 8;
   localparam int SECTOR_BITS_DEF = 48;

   // fixed field widths
   localparam int LSEC_W  = 48;
   localparam int EXT_W   = 32;
   localparam int SIZE_W  = 25;
   localparam int COUNT_W = 4;
   localparam int SLOT_W  = 3;
   localparam int DISK_W  = 8;
   localparam int CSR_W   = 32;
   localparam int CSRI_W  = 3;
   // remainder inside one extent row: below 8 * 2^25
   localparam int REM_W   = 28;

   // register codes
   typedef enum logic [CSRI_W-1:0] {
      CSR_EXTENT_SIZE   = 3'd0,
      CSR_STRIPE_COUNT  = 3'd1,
      CSR_STRIPE_SIZE   = 3'd2,
      CSR_SEG_START     = 3'd3,
      CSR_SEG_COUNT     = 3'd4
   } csr_index_type;

   // status codes
   localparam logic [1:0] STATUS_MAPPED  = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_WRITTEN = 2'd2;

   // operation codes
   localparam logic OP_MAP   = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // input word as it travels down the pipe
   typedef struct packed {
      logic              op;
      logic [SLOT_W-1:0] slot;
      logic [EXT_W-1:0]  first_extent;
      logic [LSEC_W-1:0] base_sector;
      logic [DISK_W-1:0] disk;
   } item_type;

   // item plus early check results
   typedef struct packed {
      item_type          item;
      logic              outside;
      logic              linear;
      logic [SIZE_W-1:0] r0;
   } info_type;

   // info plus offset inside the stripe chunk
   typedef struct packed {
      info_type          info;
      logic [SIZE_W-1:0] chunk_rem;
   } chunk_info_type;

   // result word
   typedef struct packed {
      logic [1:0]        status;
      logic [LSEC_W-1:0] physical_sector;
      logic [DISK_W-1:0] disk;
   } rsp_word_type;

endpackage

/* rtl/svam_div_cell.sv */
// ----------------------------------------------------------------------------
// svam_div_cell: one restoring division step
// Takes one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in; side data rides along.
// ----------------------------------------------------------------------------
module svam_div_cell #(
   parameter int N = 32,
   parameter int D = 8,
   parameter int P = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [D-1:0] divisor,
   input  logic         up_valid,
   input  logic [N-1:0] up_num,
   input  logic [D-1:0] up_rem,
   input  logic [P-1:0] up_side,
   output logic         dn_valid,
   output logic [N-1:0] dn_num,
   output logic [D-1:0] dn_rem,
   output logic [P-1:0] dn_side
);

   logic         valid_ff;
   logic [N-1:0] num_ff, num_in;
   logic [D-1:0] rem_ff, rem_in;
   logic [P-1:0] side_ff;
   logic [D:0]   trial;
   logic [D:0]   diff;
   logic         fits;

   // compare and subtract
   always_comb begin
      trial  = {up_rem, up_num[N-1]};
      diff   = trial - {1'b0, divisor};
      fits   = trial >= {1'b0, divisor};
      rem_in = fits ? diff[D-1:0] : trial[D-1:0];
      num_in = {up_num[N-2:0], fits};
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= num_in;
         rem_ff  <= rem_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_num   = num_ff;
   assign dn_rem   = rem_ff;
   assign dn_side  = side_ff;

endmodule

/* rtl/svam_div_chain.sv */
// ----------------------------------------------------------------------------
// svam_div_chain: pipelined divider built from a row of division cells
// One cell per quotient bit; a new dividend may enter every cycle that en is
// high. After N cells the shifted word is the quotient; the remainder is final.
// ----------------------------------------------------------------------------
module svam_div_chain #(
   parameter int N = 32,
   parameter int D = 8,
   parameter int P = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [D-1:0] divisor,
   input  logic         in_valid,
   input  logic [N-1:0] in_dividend,
   input  logic [P-1:0] in_side,
   output logic         out_valid,
   output logic [N-1:0] out_quotient,
   output logic [D-1:0] out_remainder,
   output logic [P-1:0] out_side
);

   logic         valid_w [0:N];
   logic [N-1:0] num_w   [0:N];
   logic [D-1:0] rem_w   [0:N];
   logic [P-1:0] side_w  [0:N];

   // chain head
   assign valid_w[0] = in_valid;
   assign num_w[0]   = in_dividend;
   assign rem_w[0]   = '0;
   assign side_w[0]  = in_side;

   // row of cells, msb first
   for (genvar i = 0; i < N; i++) begin : g_cell
      svam_div_cell #(
         .N (N),
         .D (D),
         .P (P)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .divisor  (divisor),
         .up_valid (valid_w[i]),
         .up_num   (num_w[i]),
         .up_rem   (rem_w[i]),
         .up_side  (side_w[i]),
         .dn_valid (valid_w[i+1]),
         .dn_num   (num_w[i+1]),
         .dn_rem   (rem_w[i+1]),
         .dn_side  (side_w[i+1])
      );
   end

   assign out_valid     = valid_w[N];
   assign out_quotient  = num_w[N];
   assign out_remainder = rem_w[N];
   assign out_side      = side_w[N];

endmodule

/* rtl/striped_volume_address_mapper.sv */
// ----------------------------------------------------------------------------
// striped_volume_address_mapper: logical sector to disk and physical sector
// Table writes and address maps share one pipe built from four chains of
// division cells; one word per cycle while req_stall is low, results in order.
// ----------------------------------------------------------------------------
//  channel  ports     handshake             carries
//  request  req_*     req_valid/req_stall   operation, address, table entry
//  response rsp_*     rsp_valid/rsp_stall   status, physical sector, disk
//  csr      csr_*     csr_write_enable      register index and data
//
// one word accepted per cycle while req_stall is low; the pipe holds 48 + 32 +
// 28 + 28 cell stages of the extent, row, chunk and stripe dividers plus five
// register stages (the last one is the output register)
// table writes land in the table stage in order, so maps see earlier writes
// reset is synchronous; clears valid bits and loads register defaults
// a stalled response word parks in a skid register; req_stall is high only
// while that skid register is full
module striped_volume_address_mapper #(
   parameter int MAX_STRIPES = svam_pkg::MAX_STRIPES_DEF,
   parameter int SECTOR_BITS = svam_pkg::SECTOR_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic [svam_pkg::LSEC_W-1:0]  req_logical_sector,
   input  logic [svam_pkg::SLOT_W-1:0]  req_entry_slot,
   input  logic [svam_pkg::EXT_W-1:0]   req_entry_first_extent,
   input  logic [svam_pkg::LSEC_W-1:0]  req_entry_base_sector,
   input  logic [svam_pkg::DISK_W-1:0]  req_entry_disk,
   // response
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [svam_pkg::LSEC_W-1:0]  rsp_physical_sector,
   output logic [svam_pkg::DISK_W-1:0]  rsp_disk,
   // csr
   input  logic                         csr_write_enable,
   input  logic [svam_pkg::CSRI_W-1:0]  csr_index,
   input  logic [svam_pkg::CSR_W-1:0]   csr_write_data
);

   localparam int SB     = SECTOR_BITS;
   localparam int IW     = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
   localparam int P_A    = $bits(svam_pkg::item_type);
   localparam int P_C    = $bits(svam_pkg::info_type);
   localparam int P_E    = $bits(svam_pkg::info_type) + SB;
   localparam int P_F    = $bits(svam_pkg::chunk_info_type) + SB;
   localparam int PCS_W  = svam_pkg::REM_W + svam_pkg::SIZE_W;
   localparam int PROD_W = svam_pkg::EXT_W + svam_pkg::SIZE_W;

   // ------------------------------------------------------------------
   // configuration registers
   logic [svam_pkg::SIZE_W-1:0]  es_ff;
   logic [svam_pkg::COUNT_W-1:0] sc_ff;
   logic [svam_pkg::SIZE_W-1:0]  ss_ff;
   logic [svam_pkg::EXT_W-1:0]   sse_ff;
   logic [svam_pkg::EXT_W-1:0]   sec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         es_ff  <= 25'd8192;
         sc_ff  <= 4'd1;
         ss_ff  <= 25'd128;
         sse_ff <= '0;
         sec_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (svam_pkg::csr_index_type'(csr_index))
            svam_pkg::CSR_EXTENT_SIZE:  es_ff  <= csr_write_data[svam_pkg::SIZE_W-1:0];
            svam_pkg::CSR_STRIPE_COUNT: sc_ff  <= csr_write_data[svam_pkg::COUNT_W-1:0];
            svam_pkg::CSR_STRIPE_SIZE:  ss_ff  <= csr_write_data[svam_pkg::SIZE_W-1:0];
            svam_pkg::CSR_SEG_START:    sse_ff <= csr_write_data;
            svam_pkg::CSR_SEG_COUNT:    sec_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // pipe advance: frozen only while the skid register holds a word
   logic skid_valid_ff;
   logic rsp_valid_ff;
   logic en;
   logic accept;
   svam_pkg::item_type req_item;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   always_comb begin
      req_item.op           = req_operation;
      req_item.slot         = req_entry_slot;
      req_item.first_extent = req_entry_first_extent;
      req_item.base_sector  = req_entry_base_sector;
      req_item.disk         = req_entry_disk;
   end

   // ------------------------------------------------------------------
   // extent divider: lsec / extent size
   logic                        a_valid;
   logic [svam_pkg::LSEC_W-1:0] a_ext;
   logic [svam_pkg::SIZE_W-1:0] a_r0;
   logic [P_A-1:0]              a_side;

   svam_div_chain #(
      .N (svam_pkg::LSEC_W),
      .D (svam_pkg::SIZE_W),
      .P (P_A)
   ) u_ext_div (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .divisor       (es_ff),
      .in_valid      (accept),
      .in_dividend   (req_logical_sector),
      .in_side       (req_item),
      .out_valid     (a_valid),
      .out_quotient  (a_ext),
      .out_remainder (a_r0),
      .out_side      (a_side)
   );

   // ------------------------------------------------------------------
   // segment check
   logic                        b_valid_ff;
   svam_pkg::info_type          b_ff, b_in;
   logic [svam_pkg::EXT_W-1:0]  b_erel_ff;
   logic [svam_pkg::LSEC_W-1:0] ext_diff;
   logic                        below, beyond, linear;

   always_comb begin
      ext_diff = a_ext - svam_pkg::LSEC_W'(sse_ff);
      below    = a_ext < svam_pkg::LSEC_W'(sse_ff);
      beyond   = ext_diff >= svam_pkg::LSEC_W'(sec_ff);
      linear   = sc_ff == 4'd1;
      b_in.item    = a_side;
      b_in.linear  = linear;
      b_in.r0      = a_r0;
      b_in.outside = (es_ff == '0) || (sc_ff == '0) ||
                     (32'(sc_ff) > MAX_STRIPES) || below || beyond ||
                     (!linear && (ss_ff == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff      <= b_in;
         b_erel_ff <= ext_diff[svam_pkg::EXT_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // row divider: relative extent / stripe count
   logic                         c_valid;
   logic [svam_pkg::EXT_W-1:0]   c_row;
   logic [svam_pkg::COUNT_W-1:0] c_k;
   logic [P_C-1:0]               c_side;

   svam_div_chain #(
      .N (svam_pkg::EXT_W),
      .D (svam_pkg::COUNT_W),
      .P (P_C)
   ) u_row_div (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .divisor       (sc_ff),
      .in_valid      (b_valid_ff),
      .in_dividend   (b_erel_ff),
      .in_side       (b_ff),
      .out_valid     (c_valid),
      .out_quotient  (c_row),
      .out_remainder (c_k),
      .out_side      (c_side)
   );

   // ------------------------------------------------------------------
   // row offset and row base
   logic                                        d_valid_ff;
   svam_pkg::info_type                          d_ff, c_info;
   logic [svam_pkg::REM_W-1:0]                  d_rem_ff;
   logic [SB-1:0]                               d_row_es_ff;
   logic [svam_pkg::COUNT_W+svam_pkg::SIZE_W-1:0] k_es;
   logic [svam_pkg::COUNT_W+svam_pkg::SIZE_W:0]   rem_sum;
   logic [PROD_W-1:0]                           row_es;

   always_comb begin
      c_info  = c_side;
      k_es    = {{svam_pkg::SIZE_W{1'b0}}, c_k} * {{svam_pkg::COUNT_W{1'b0}}, es_ff};
      rem_sum = {1'b0, k_es} + (svam_pkg::COUNT_W + svam_pkg::SIZE_W + 1)'(c_info.r0);
      row_es  = {{svam_pkg::SIZE_W{1'b0}}, c_row} * {{svam_pkg::EXT_W{1'b0}}, es_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff        <= c_info;
         d_rem_ff    <= rem_sum[svam_pkg::REM_W-1:0];
         d_row_es_ff <= SB'(row_es);
      end
   end

   // ------------------------------------------------------------------
   // chunk divider: row offset / chunk size
   logic                        e_valid;
   logic [svam_pkg::REM_W-1:0]  e_chunk;
   logic [svam_pkg::SIZE_W-1:0] e_chunk_rem;
   logic [P_E-1:0]              e_side;
   svam_pkg::chunk_info_type    e_cinfo;

   svam_div_chain #(
      .N (svam_pkg::REM_W),
      .D (svam_pkg::SIZE_W),
      .P (P_E)
   ) u_chunk_div (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .divisor       (ss_ff),
      .in_valid      (d_valid_ff),
      .in_dividend   (d_rem_ff),
      .in_side       ({d_ff, d_row_es_ff}),
      .out_valid     (e_valid),
      .out_quotient  (e_chunk),
      .out_remainder (e_chunk_rem),
      .out_side      (e_side)
   );

   always_comb begin
      e_cinfo.info      = e_side[P_E-1:SB];
      e_cinfo.chunk_rem = e_chunk_rem;
   end

   // ------------------------------------------------------------------
   // stripe divider: chunk / stripe count
   logic                         f_valid;
   logic [svam_pkg::REM_W-1:0]   f_cir;
   logic [svam_pkg::COUNT_W-1:0] f_idx;
   logic [P_F-1:0]               f_side;
   svam_pkg::chunk_info_type     f_cinfo;
   logic [SB-1:0]                f_row_es;

   svam_div_chain #(
      .N (svam_pkg::REM_W),
      .D (svam_pkg::COUNT_W),
      .P (P_F)
   ) u_stripe_div (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .divisor       (sc_ff),
      .in_valid      (e_valid),
      .in_dividend   (e_chunk),
      .in_side       ({e_cinfo, e_side[SB-1:0]}),
      .out_valid     (f_valid),
      .out_quotient  (f_cir),
      .out_remainder (f_idx),
      .out_side      (f_side)
   );

   assign f_cinfo  = f_side[P_F-1:SB];
   assign f_row_es = f_side[SB-1:0];

   // ------------------------------------------------------------------
   // stripe table: written and read in order at this stage
   logic [svam_pkg::EXT_W-1:0]  tab_fe   [MAX_STRIPES];
   logic [SB-1:0]               tab_base [MAX_STRIPES];
   logic [svam_pkg::DISK_W-1:0] tab_disk [MAX_STRIPES];
   logic [IW-1:0]               rd_idx;
   logic                        wr_en;

   logic                        g_valid_ff;
   svam_pkg::chunk_info_type    g_ff;
   logic [SB-1:0]               g_row_es_ff;
   logic [PCS_W-1:0]            g_pcs_ff;
   logic [svam_pkg::EXT_W-1:0]  g_fe_ff;
   logic [SB-1:0]               g_base_ff;
   logic [svam_pkg::DISK_W-1:0] g_disk_ff;

   always_comb begin
      if (f_cinfo.info.linear || (32'(f_idx) >= MAX_STRIPES)) begin
         rd_idx = '0;
      end else begin
         rd_idx = IW'(f_idx);
      end
      wr_en = en && f_valid && (f_cinfo.info.item.op == svam_pkg::OP_WRITE) &&
              (32'(f_cinfo.info.item.slot) < MAX_STRIPES);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tab_fe[IW'(f_cinfo.info.item.slot)]   <= f_cinfo.info.item.first_extent;
         tab_base[IW'(f_cinfo.info.item.slot)] <= SB'(f_cinfo.info.item.base_sector);
         tab_disk[IW'(f_cinfo.info.item.slot)] <= f_cinfo.info.item.disk;
      end
      if (en) begin
         g_fe_ff   <= tab_fe[rd_idx];
         g_base_ff <= tab_base[rd_idx];
         g_disk_ff <= tab_disk[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (en) begin
         g_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff        <= f_cinfo;
         g_row_es_ff <= f_row_es;
         g_pcs_ff    <= {{svam_pkg::SIZE_W{1'b0}}, f_cir} *
                        {{svam_pkg::REM_W{1'b0}}, ss_ff};
      end
   end

   // ------------------------------------------------------------------
   // chunk bound check and partial sum
   logic                        h_valid_ff;
   logic                        h_op_ff;
   logic                        h_outside_ff;
   logic [SB-1:0]               h_a_ff, a_in, x_term;
   logic [SB-1:0]               h_fe_es_ff;
   logic [svam_pkg::DISK_W-1:0] h_disk_ff;
   logic [PROD_W-1:0]           fe_es;
   logic [PCS_W:0]              chunk_end;
   logic                        past;

   always_comb begin
      fe_es     = {{svam_pkg::SIZE_W{1'b0}}, g_fe_ff} * {{svam_pkg::EXT_W{1'b0}}, es_ff};
      chunk_end = {1'b0, g_pcs_ff} + (PCS_W + 1)'(ss_ff);
      past      = !g_ff.info.linear && (chunk_end > (PCS_W + 1)'(es_ff));
      if (g_ff.info.linear) begin
         x_term = SB'(g_ff.info.r0);
      end else begin
         x_term = SB'(g_pcs_ff) + SB'(g_ff.chunk_rem);
      end
      a_in = g_row_es_ff + g_base_ff + x_term;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (en) begin
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_op_ff      <= g_ff.info.item.op;
         h_outside_ff <= g_ff.info.outside || past;
         h_a_ff       <= a_in;
         h_fe_es_ff   <= SB'(fe_es);
         h_disk_ff    <= g_disk_ff;
      end
   end

   // ------------------------------------------------------------------
   // final sum and result word
   svam_pkg::rsp_word_type new_word;
   logic [SB-1:0]          sum;

   always_comb begin
      sum = h_a_ff + h_fe_es_ff;
      new_word.physical_sector = '0;
      new_word.disk            = '0;
      if (h_op_ff == svam_pkg::OP_WRITE) begin
         new_word.status = svam_pkg::STATUS_WRITTEN;
      end else if (h_outside_ff) begin
         new_word.status = svam_pkg::STATUS_OUTSIDE;
      end else begin
         new_word.status          = svam_pkg::STATUS_MAPPED;
         new_word.physical_sector = svam_pkg::LSEC_W'(sum);
         new_word.disk            = h_disk_ff;
      end
   end

   // ------------------------------------------------------------------
   // output register with skid
   svam_pkg::rsp_word_type rsp_word_ff;
   svam_pkg::rsp_word_type skid_word_ff;
   logic pop;

   assign pop = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (h_valid_ff) begin
         if (!rsp_valid_ff || pop) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_word_ff <= skid_word_ff;
         end
      end else if (h_valid_ff) begin
         if (!rsp_valid_ff || pop) begin
            rsp_word_ff <= new_word;
         end else begin
            skid_word_ff <= new_word;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_word_ff.status;
   assign rsp_physical_sector = rsp_word_ff.physical_sector;
   assign rsp_disk            = rsp_word_ff.disk;

`ifndef SYNTH
   // skid only holds a word behind a waiting output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word without output word");

   // skid fills only when the output word was stalled
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled without a stall");

   // only mapped words carry a sector and a disk
   a_zero_unless_mapped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_word_ff.status != svam_pkg::STATUS_MAPPED)) |->
      ((rsp_word_ff.physical_sector == '0) && (rsp_word_ff.disk == '0)))
      else $error("unmapped word with nonzero fields");

   // pipe is frozen while the skid register is full
   a_frozen_pipe: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && $past(skid_valid_ff)) |-> $stable(h_valid_ff))
      else $error("pipe moved while frozen");
`endif

endmodule

/* tb/sv/svam_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// svam_checker: result predictor and scoreboard for the address mapper
// Watches the csr port and both channels, keeps its own copy of the registers
// and the stripe table, predicts one result word per accepted request word and
// compares every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module svam_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        req_operation,
   input  logic [svam_pkg::LSEC_W-1:0] req_logical_sector,
   input  logic [svam_pkg::SLOT_W-1:0] req_entry_slot,
   input  logic [svam_pkg::EXT_W-1:0]  req_entry_first_extent,
   input  logic [svam_pkg::LSEC_W-1:0] req_entry_base_sector,
   input  logic [svam_pkg::DISK_W-1:0] req_entry_disk,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [1:0]                  rsp_status,
   input  logic [svam_pkg::LSEC_W-1:0] rsp_physical_sector,
   input  logic [svam_pkg::DISK_W-1:0] rsp_disk,
   input  logic                        csr_write_enable,
   input  logic [svam_pkg::CSRI_W-1:0] csr_index,
   input  logic [svam_pkg::CSR_W-1:0]  csr_write_data,
   output int                          errors,
   output int                          pending
);

   localparam int NSTRIPES = svam_pkg::MAX_STRIPES_DEF;
   localparam logic [63:0] SECTOR_MASK = (64'd1 << svam_pkg::SECTOR_BITS_DEF) - 64'd1;

   // register copy
   logic [63:0] ext_size, stripes, chunk_size, seg_first, seg_len;
   // stripe table copy
   logic [63:0] tbl_first [NSTRIPES];
   logic [63:0] tbl_base  [NSTRIPES];
   logic [7:0]  tbl_disk  [NSTRIPES];

   svam_pkg::rsp_word_type expected_words[$];

   function automatic svam_pkg::rsp_word_type map_word(input logic [63:0] lsec);
      svam_pkg::rsp_word_type w;
      logic [63:0] ext, rel, sum, idx, row_len, row, rem, chunk, chunk_in_row;
      w = '0;
      w.status = svam_pkg::STATUS_OUTSIDE;
      if (ext_size == 0 || stripes == 0 || stripes > NSTRIPES) return w;
      ext = lsec / ext_size;
      if (ext < seg_first || ext - seg_first >= seg_len) return w;
      rel = lsec - seg_first * ext_size;
      if (stripes == 1) begin
         idx = 0;
         sum = rel + tbl_first[0] * ext_size;
      end else begin
         if (chunk_size == 0) return w;
         row_len = ext_size * stripes;
         row = rel / row_len;
         rem = rel % row_len;
         chunk = rem / chunk_size;
         idx = chunk % stripes;
         chunk_in_row = chunk / stripes;
         if (chunk_in_row >= ext_size / chunk_size) return w;
         sum = rem % chunk_size + tbl_first[idx] * ext_size + row * ext_size
               + chunk_in_row * chunk_size;
      end
      sum = (sum + tbl_base[idx]) & SECTOR_MASK;
      w.status = svam_pkg::STATUS_MAPPED;
      w.physical_sector = sum[svam_pkg::LSEC_W-1:0];
      w.disk = tbl_disk[idx];
      return w;
   endfunction

   always @(posedge clock) begin
      svam_pkg::rsp_word_type exp_w;
      if (reset) begin
         ext_size   <= 64'd8192;
         stripes    <= 64'd1;
         chunk_size <= 64'd128;
         seg_first  <= 64'd0;
         seg_len    <= 64'd0;
         expected_words.delete();
         errors = 0;
         pending <= 0;
      end else begin
         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               svam_pkg::CSR_EXTENT_SIZE:
                  ext_size   <= 64'(csr_write_data[svam_pkg::SIZE_W-1:0]);
               svam_pkg::CSR_STRIPE_COUNT:
                  stripes    <= 64'(csr_write_data[svam_pkg::COUNT_W-1:0]);
               svam_pkg::CSR_STRIPE_SIZE:
                  chunk_size <= 64'(csr_write_data[svam_pkg::SIZE_W-1:0]);
               svam_pkg::CSR_SEG_START:  seg_first <= 64'(csr_write_data);
               svam_pkg::CSR_SEG_COUNT:  seg_len   <= 64'(csr_write_data);
               default: ;
            endcase
         end
         // compare result word with oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected");
               errors++;
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_status !== exp_w.status) begin
                  $error("status expected %0d actual %0d", exp_w.status, rsp_status);
                  errors++;
               end
               if (rsp_physical_sector !== exp_w.physical_sector) begin
                  $error("physical_sector expected %0h actual %0h",
                         exp_w.physical_sector, rsp_physical_sector);
                  errors++;
               end
               if (rsp_disk !== exp_w.disk) begin
                  $error("disk expected %0d actual %0d", exp_w.disk, rsp_disk);
                  errors++;
               end
            end
         end
         // predict for accepted request word
         if (req_valid && !req_stall) begin
            if (req_operation == svam_pkg::OP_WRITE) begin
               if (req_entry_slot < NSTRIPES) begin
                  tbl_first[req_entry_slot] = 64'(req_entry_first_extent);
                  tbl_base[req_entry_slot]  = 64'(req_entry_base_sector) & SECTOR_MASK;
                  tbl_disk[req_entry_slot]  = req_entry_disk;
               end
               exp_w = '0;
               exp_w.status = svam_pkg::STATUS_WRITTEN;
            end else begin
               exp_w = map_word(64'(req_logical_sector));
            end
            expected_words.insert(expected_words.size(), exp_w);
         end
         pending <= expected_words.size();
      end
   end

endmodule

/* tb/sv/tb_striped_volume_address_mapper.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_striped_volume_address_mapper: stimulus and verdict for the mapper
// Loads the stripe table, runs directed maps over the edge cases, then random
// register settings with mostly in-segment addresses under changing idle and
// stall pressure. Checking is done by svam_checker.
// ----------------------------------------------------------------------------
module tb_striped_volume_address_mapper;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_operation = svam_pkg::OP_MAP;
   logic [svam_pkg::LSEC_W-1:0] req_logical_sector = '0;
   logic [svam_pkg::SLOT_W-1:0] req_entry_slot = '0;
   logic [svam_pkg::EXT_W-1:0]  req_entry_first_extent = '0;
   logic [svam_pkg::LSEC_W-1:0] req_entry_base_sector = '0;
   logic [svam_pkg::DISK_W-1:0] req_entry_disk = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [1:0]                  rsp_status;
   logic [svam_pkg::LSEC_W-1:0] rsp_physical_sector;
   logic [svam_pkg::DISK_W-1:0] rsp_disk;
   logic                        csr_write_enable = 1'b0;
   logic [svam_pkg::CSRI_W-1:0] csr_index = '0;
   logic [svam_pkg::CSR_W-1:0]  csr_write_data = '0;
   int                          errors, pending;
   int                          idle_pct = 0, stall_pct = 0;

   localparam logic [63:0] LSEC_MAX = (64'd1 << svam_pkg::LSEC_W) - 64'd1;

   always #5 clock = ~clock;

   striped_volume_address_mapper i_dut (.*);

   svam_checker i_checker (.*);

   // receiver stall
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // hard stop
   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_word(input logic op, input logic [63:0] lsec, input logic [2:0] slot,
                            input logic [31:0] fe, input logic [47:0] base,
                            input logic [7:0] dk);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_logical_sector <= lsec[svam_pkg::LSEC_W-1:0];
      req_entry_slot <= slot;
      req_entry_first_extent <= fe;
      req_entry_base_sector <= base;
      req_entry_disk <= dk;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic map_sector(input logic [63:0] lsec);
      send_word(svam_pkg::OP_MAP, lsec, 3'($urandom), $urandom,
                {16'($urandom), 32'($urandom)}, 8'($urandom));
   endtask

   task automatic load_entry(input logic [2:0] slot);
      send_word(svam_pkg::OP_WRITE, 64'({16'($urandom), 32'($urandom)}), slot, $urandom,
                {16'($urandom), 32'($urandom)}, 8'($urandom));
   endtask

   // wait until every predicted word has come back
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // all five registers, written while the block is idle
   task automatic set_regs(input logic [31:0] es, input logic [31:0] cnt,
                           input logic [31:0] ss, input logic [31:0] first,
                           input logic [31:0] len);
      logic [31:0] vals[5];
      vals = '{es, cnt, ss, first, len};
      drain();
      for (int i = 0; i < 5; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= svam_pkg::csr_index_type'(i);
         csr_write_data <= vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [63:0] es, cnt, ss, first, len, max_ext, room, ext, lsec;
      int r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: load whole table, extremes in the entry fields
      for (int s = 0; s < 8; s++) load_entry(3'(s));
      send_word(svam_pkg::OP_WRITE, LSEC_MAX, 3'd7, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                8'hFF);
      send_word(svam_pkg::OP_WRITE, 64'd0, 3'd6, 32'd0, 48'd0, 8'd0);
      // empty segment under reset values
      map_sector(64'd0);
      // linear mode, first and last sector of segment, one before and one past it
      set_regs(8192, 1, 128, 2, 4);
      map_sector(64'd16384);
      map_sector(64'd49151);
      map_sector(64'd49152);
      map_sector(64'd16383);
      // striped with chunk past extent (4 does not divide 10)
      set_regs(10, 3, 4, 0, 5);
      for (int i = 0; i < 30; i += 3) map_sector(64'(i));
      // no stripes, too many stripes, zero sizes
      set_regs(10, 0, 4, 0, 5);
      map_sector(64'd1);
      set_regs(10, 15, 4, 0, 5);
      map_sector(64'd1);
      set_regs(0, 1, 4, 0, 5);
      map_sector(64'd1);
      set_regs(10, 4, 0, 0, 5);
      map_sector(64'd1);
      // overflow of the sum, largest sizes and highest extents
      set_regs(32'h100_0000, 8, 32'h100_0000, 32'h00FF_FFF0, 32'hFFFF_FFFF);
      map_sector(LSEC_MAX);
      map_sector(LSEC_MAX - 64'h100_0000);
      set_regs(32'h100_0000, 1, 1, 0, 32'hFFFF_FFFF);
      map_sector(LSEC_MAX);

      // random settings, idle and stall pressure cycle through the phases
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 5)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 71; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 71; end
            3: begin idle_pct = 30; stall_pct = 30; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         r = $urandom_range(9);
         es = (r == 0) ? 1 : (r == 1) ? 64'h100_0000 :
              (r < 6) ? (64'd1 << $urandom_range(8)) : $urandom_range(1, 300);
         r = $urandom_range(19);
         cnt = 64'((r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8));
         r = $urandom_range(9);
         ss = (r == 0) ? 0 : (r < 3) ? $urandom_range(1, 300) : es / $urandom_range(1, 8);
         if (ss == 0 && r != 0) ss = 1;
         max_ext = LSEC_MAX / es;
         first = (max_ext > 64'hFFFF_FFFF && $urandom_range(1)) ? 64'($urandom) :
                 64'($urandom) % (max_ext / 2 + 1);
         len = ($urandom_range(7) == 0) ? 64'hFFFF_FFFF : $urandom_range(1, 64);
         set_regs(es[31:0], cnt[31:0], ss[31:0], first[31:0], len[31:0]);
         room = max_ext - first + 1;
         if (room > len) room = len;
         for (int i = 0; i < 80; i++) begin
            r = $urandom_range(99);
            if (r < 15) begin
               load_entry(3'($urandom));
            end else if (r < 25) begin
               map_sector(64'({16'($urandom), 32'($urandom)}));
            end else if (r < 32) begin
               ext = $urandom_range(1) ? first + len : first - 1;
               lsec = ext * es + 64'($urandom) % es;
               map_sector(lsec > LSEC_MAX ? LSEC_MAX : lsec);
            end else begin
               ext = first + 64'($urandom) % room;
               lsec = ext * es + 64'($urandom) % es;
               map_sector(lsec > LSEC_MAX ? LSEC_MAX : lsec);
            end
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
